[sv/rsb_pkg.sv]
// rsb_pkg: shared types, constants and code points of the rle sprite blitter
// used by rsb_decode and rle_sprite_blend_blitter_unit, depends on nothing

package rsb_pkg;

  // framebuffer geometry
  localparam int unsigned FB_AW    = 16;
  localparam int unsigned FB_WORDS = 1 << FB_AW;

  localparam int unsigned PIX_W  = 16;
  localparam int unsigned LEN_W  = 13;
  localparam int unsigned KIND_W = 3;
  localparam int unsigned CFG_AW = 3;
  localparam int unsigned CFG_DW = 11;

  // run kinds held in the top bits of a code word
  localparam logic [KIND_W-1:0] KIND_TRANSP = 3'd0;
  localparam logic [KIND_W-1:0] KIND_QTR    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_HALF   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_3QTR   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_COPY   = 3'd4;

  // kinds above copy skip (SKIP_BASE - kind) words
  localparam logic [3:0] SKIP_BASE = 4'd8;

  localparam logic [PIX_W-1:0] MASK_QTR  = 16'he79c;
  localparam logic [PIX_W-1:0] MASK_HALF = 16'hf7de;

  // configuration register indexes
  localparam logic [CFG_AW-1:0] CFG_SCREEN_W = 3'd0;
  localparam logic [CFG_AW-1:0] CFG_POS_X    = 3'd1;
  localparam logic [CFG_AW-1:0] CFG_POS_Y    = 3'd2;
  localparam logic [CFG_AW-1:0] CFG_PIC_W    = 3'd3;
  localparam logic [CFG_AW-1:0] CFG_PIC_H    = 3'd4;
  localparam logic [CFG_AW-1:0] CFG_MODE     = 3'd5;

  typedef struct packed {
    logic [10:0] screen_width;
    logic [9:0]  pos_x;
    logic [9:0]  pos_y;
    logic [10:0] pic_width;
    logic [9:0]  pic_height;
    logic        mode;
  } cfg_t;

  // one pixel write requested by the stream decoder
  typedef struct packed {
    logic              valid;
    logic [FB_AW-1:0]  addr;
    logic [KIND_W-1:0] kind;
    logic              last;
  } pix_t;

endpackage

[sv/rsb_decode.sv]
// rsb_decode: run-length stream decoder, tracks rows, runs and the write address
// depends on rsb_pkg for the config struct, pixel request struct and run kinds

module rsb_decode (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                take_i,
  input  logic                start_i,
  input  logic [15:0]         word_i,
  input  rsb_pkg::cfg_t       cfg_i,
  output rsb_pkg::pix_t       pix_o
);

  localparam logic [1:0] PH_ROWCNT = 2'd0;
  localparam logic [1:0] PH_CODE   = 2'd1;
  localparam logic [1:0] PH_PIX    = 2'd2;
  localparam logic [1:0] PH_SKIP   = 2'd3;

  logic [1:0]                     phase_q, phase_d;
  logic [9:0]                     rows_q, rows_d;
  logic [15:0]                    runs_q, runs_d;
  logic [rsb_pkg::LEN_W-1:0]      pixl_q, pixl_d;
  logic [rsb_pkg::KIND_W-1:0]     kind_q, kind_d;
  logic [rsb_pkg::FB_AW-1:0]      addr_q, addr_d;

  logic [20:0]                    base_prod;
  logic [rsb_pkg::FB_AW-1:0]      base_addr;
  logic [rsb_pkg::FB_AW-1:0]      pitch;
  logic [rsb_pkg::LEN_W-1:0]      run_len;
  logic [rsb_pkg::KIND_W-1:0]     code_kind;
  logic                           do_finish;
  logic                           do_end_row;

  assign base_prod = 21'(cfg_i.pos_y) * 21'(cfg_i.screen_width);
  assign base_addr = base_prod[rsb_pkg::FB_AW-1:0] + rsb_pkg::FB_AW'(cfg_i.pos_x);
  // negative pitch wraps modulo the framebuffer
  assign pitch     = rsb_pkg::FB_AW'(cfg_i.screen_width) - rsb_pkg::FB_AW'(cfg_i.pic_width);
  assign run_len   = word_i[rsb_pkg::LEN_W-1:0];
  assign code_kind = word_i[15:rsb_pkg::LEN_W];

  always_comb begin
    phase_d    = phase_q;
    rows_d     = rows_q;
    runs_d     = runs_q;
    pixl_d     = pixl_q;
    kind_d     = kind_q;
    addr_d     = addr_q;
    do_finish  = 1'b0;
    do_end_row = 1'b0;
    pix_o      = '0;

    if (start_i) begin
      addr_d  = base_addr;
      rows_d  = cfg_i.pic_height;
      runs_d  = '0;
      pixl_d  = '0;
      phase_d = PH_ROWCNT;
    end

    unique case (phase_d)
      PH_ROWCNT: begin
        // a row count with no rows left is dropped
        if (rows_d != '0) begin
          runs_d = word_i;
          if (word_i == '0) begin
            do_end_row = 1'b1;
          end else begin
            phase_d = PH_CODE;
          end
        end
      end
      PH_CODE: begin
        kind_d = code_kind;
        if (code_kind == rsb_pkg::KIND_TRANSP) begin
          addr_d    = addr_d + rsb_pkg::FB_AW'(run_len);
          do_finish = 1'b1;
        end else if (code_kind <= rsb_pkg::KIND_COPY) begin
          if (run_len == '0) begin
            do_finish = 1'b1;
          end else begin
            pixl_d  = run_len;
            phase_d = PH_PIX;
          end
        end else begin
          pixl_d  = rsb_pkg::LEN_W'(rsb_pkg::SKIP_BASE - {1'b0, code_kind});
          phase_d = PH_SKIP;
        end
      end
      PH_PIX: begin
        pix_o.valid = take_i;
        pix_o.addr  = addr_d;
        pix_o.kind  = kind_d;
        addr_d      = addr_d + 1'b1;
        if (pixl_d != '0) pixl_d = pixl_d - 1'b1;
        if (pixl_d == '0) do_finish = 1'b1;
      end
      default: begin
        if (pixl_d != '0) pixl_d = pixl_d - 1'b1;
        if (pixl_d == '0) do_finish = 1'b1;
      end
    endcase

    if (do_finish) begin
      if (runs_d != '0) runs_d = runs_d - 1'b1;
      if (runs_d == '0) begin
        do_end_row = 1'b1;
      end else begin
        phase_d = PH_CODE;
      end
    end

    if (do_end_row) begin
      addr_d = addr_d + pitch;
      if (rows_d != '0) rows_d = rows_d - 1'b1;
      phase_d = PH_ROWCNT;
    end

    pix_o.last = (rows_d == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_ROWCNT;
      rows_q  <= '0;
      runs_q  <= '0;
      pixl_q  <= '0;
      kind_q  <= '0;
      addr_q  <= '0;
    end else if (take_i) begin
      phase_q <= phase_d;
      rows_q  <= rows_d;
      runs_q  <= runs_d;
      pixl_q  <= pixl_d;
      kind_q  <= kind_d;
      addr_q  <= addr_d;
    end
  end

endmodule

[sv/rle_sprite_blend_blitter_unit.sv]
// rle_sprite_blend_blitter_unit: top level, config registers, framebuffer memory,
// read-modify-write stage and output register; depends on rsb_pkg and rsb_decode
//
//  channel  | direction | handshake                | payload
//  ---------+-----------+--------------------------+---------------------------------
//  in       | sink      | in_valid_i / in_ready_o  | start_req, rle_word, saved_pixel
//  out      | source    | out_valid_o / out_ready_i| pixel_address, new/old_pixel, last
//  cfg      | sink      | cfg_we_i (no wait)       | cfg_addr_i, cfg_wdata_i
//
// one stream word per cycle while in_ready_o is high; the decoder updates on acceptance
// a pixel word reads the framebuffer at acceptance and writes back from the pixel stage;
// one write port and same-address forwarding keep this at 1/cycle unless output stalls
// after reset the framebuffer is cleared, one word a cycle, with in_ready_o low
// a stalled output holds the result register and the pixel stage, then input stalls

module rle_sprite_blend_blitter_unit (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_addr_i,
  input  logic [10:0] cfg_wdata_i,

  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        start_req_i,
  input  logic [15:0] rle_word_i,
  input  logic [15:0] saved_pixel_i,

  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] pixel_address_o,
  output logic [15:0] new_pixel_o,
  output logic [15:0] old_pixel_o,
  output logic        last_of_picture_o
);

  localparam int unsigned AW = rsb_pkg::FB_AW;
  localparam int unsigned PW = rsb_pkg::PIX_W;

  function automatic logic [PW-1:0] blend(input logic [rsb_pkg::KIND_W-1:0] kind,
                                          input logic [PW-1:0] old_v,
                                          input logic [PW-1:0] src_v);
    logic [PW+1:0] om;
    logic [PW+1:0] sm;
    logic [PW+1:0] sum;
    logic [PW-1:0] res;
    om  = (PW+2)'(old_v & rsb_pkg::MASK_QTR);
    sm  = (PW+2)'(src_v & rsb_pkg::MASK_QTR);
    sum = '0;
    unique case (kind)
      rsb_pkg::KIND_QTR: begin
        sum = om + (om << 1) + sm;
        res = sum[PW+1:2];
      end
      rsb_pkg::KIND_HALF: begin
        sum = (PW+2)'(old_v & rsb_pkg::MASK_HALF) + (PW+2)'(src_v & rsb_pkg::MASK_HALF);
        res = sum[PW:1];
      end
      rsb_pkg::KIND_3QTR: begin
        sum = om + sm + (sm << 1);
        res = sum[PW+1:2];
      end
      default: begin
        res = src_v;
      end
    endcase
    return res;
  endfunction

  // configuration registers
  rsb_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.screen_width <= 11'd320;
      cfg_q.pos_x        <= '0;
      cfg_q.pos_y        <= '0;
      cfg_q.pic_width    <= '0;
      cfg_q.pic_height   <= '0;
      cfg_q.mode         <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        rsb_pkg::CFG_SCREEN_W: cfg_q.screen_width <= cfg_wdata_i;
        rsb_pkg::CFG_POS_X:    cfg_q.pos_x        <= cfg_wdata_i[9:0];
        rsb_pkg::CFG_POS_Y:    cfg_q.pos_y        <= cfg_wdata_i[9:0];
        rsb_pkg::CFG_PIC_W:    cfg_q.pic_width    <= cfg_wdata_i;
        rsb_pkg::CFG_PIC_H:    cfg_q.pic_height   <= cfg_wdata_i[9:0];
        rsb_pkg::CFG_MODE:     cfg_q.mode         <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // clearing pass
  logic          clr_busy_q;
  logic [AW-1:0] clr_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else if (clr_busy_q) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
      if (clr_cnt_q == '1) clr_busy_q <= 1'b0;
    end
  end

  // pixel stage and output register
  logic                       s1_valid_q;
  logic [AW-1:0]              s1_addr_q;
  logic [PW-1:0]              s1_src_q;
  logic [PW-1:0]              s1_saved_q;
  logic [rsb_pkg::KIND_W-1:0] s1_kind_q;
  logic                       s1_mode_q;
  logic                       s1_last_q;
  logic                       s1_go;

  logic                       out_valid_q;
  logic [PW-1:0]              out_addr_q;
  logic [PW-1:0]              out_new_q;
  logic [PW-1:0]              out_old_q;
  logic                       out_last_q;

  logic                       take;
  rsb_pkg::pix_t              pix;

  assign s1_go      = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !clr_busy_q && (!s1_valid_q || s1_go);
  assign take       = in_valid_i && in_ready_o;

  rsb_decode u_decode (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .take_i  (take),
    .start_i (start_req_i),
    .word_i  (rle_word_i),
    .cfg_i   (cfg_q),
    .pix_o   (pix)
  );

  // framebuffer memory, read-first
  logic [PW-1:0] fb_mem [rsb_pkg::FB_WORDS];
  logic [PW-1:0] rd_data_q;
  logic          fwd_hit_q;
  logic [PW-1:0] fwd_data_q;
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [PW-1:0] mem_wd;
  logic [PW-1:0] old_val;
  logic [PW-1:0] new_val;

  assign old_val = fwd_hit_q ? fwd_data_q : rd_data_q;
  assign new_val = s1_mode_q ? s1_saved_q : blend(s1_kind_q, old_val, s1_src_q);

  assign mem_we = clr_busy_q || s1_go;
  assign mem_wa = clr_busy_q ? clr_cnt_q : s1_addr_q;
  assign mem_wd = clr_busy_q ? '0 : new_val;

  always_ff @(posedge clk_i) begin
    if (mem_we) fb_mem[mem_wa] <= mem_wd;
    if (pix.valid) rd_data_q <= fb_mem[pix.addr];
  end

  // a write to the address being read in the same cycle is picked up here
  always_ff @(posedge clk_i) begin
    if (pix.valid) begin
      fwd_hit_q  <= mem_we && (mem_wa == pix.addr);
      fwd_data_q <= mem_wd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (pix.valid) begin
      s1_valid_q <= 1'b1;
    end else if (s1_go) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix.valid) begin
      s1_addr_q  <= pix.addr;
      s1_src_q   <= rle_word_i;
      s1_saved_q <= saved_pixel_i;
      s1_kind_q  <= pix.kind;
      s1_mode_q  <= cfg_q.mode;
      s1_last_q  <= pix.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_go) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go) begin
      out_addr_q <= PW'(s1_addr_q);
      out_new_q  <= new_val;
      out_old_q  <= old_val;
      out_last_q <= s1_last_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign pixel_address_o   = out_addr_q;
  assign new_pixel_o       = out_new_q;
  assign old_pixel_o       = out_old_q;
  assign last_of_picture_o = out_last_q;

  // nothing is in flight while the framebuffer is being cleared
  a_clr_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |-> (!s1_valid_q && !out_valid_q && !in_ready_o))
    else $error("pipeline busy during framebuffer clear");

  // a pixel leaving the write stage lands in the output register with its address
  a_s1_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_go |=> (out_valid_q && (out_addr_q == PW'($past(s1_addr_q)))))
    else $error("pixel transaction lost between write stage and output");

  // a blocked write stage keeps its pixel and its read data
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_go) |=> (s1_valid_q && $stable(s1_addr_q) && $stable(old_val)))
    else $error("stalled write stage changed");

  // a new pixel only enters when the write stage is free or draining
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix.valid |-> (!s1_valid_q || s1_go))
    else $error("pixel transaction overwrote the write stage");

endmodule
